[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// overlapping implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/fph_pkg.sv]
// ----------------------------------------------------------------------------
// fph_pkg
// shared types, codes and defaults of the fit-policy hole allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fph_pkg;

   // default sizes of the hole table
   localparam int DEF_NUM_HOLES = 16;
   localparam int DEF_SIZE_BITS = 16;

   // fixed field widths
   localparam int IDX_FIELD_W   = 4;
   localparam int AMT_FIELD_W   = 16;
   localparam int HOLES_FIELD_W = 5;
   localparam int POLICY_W      = 2;

   // register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLES_IN_USE = 2'd1;

   localparam logic [POLICY_W-1:0]      POLICY_RESET = 2'd0;
   localparam logic [HOLES_FIELD_W-1:0] HOLES_RESET  = 5'd16;

   // placement rules
   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   // request commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [IDX_FIELD_W-1:0] hole_index;
      logic [AMT_FIELD_W-1:0] amount;
      logic                   last_request;
   } req_type;

   typedef struct packed {
      logic                   granted;
      logic [IDX_FIELD_W-1:0] chosen_hole;
      logic [AMT_FIELD_W-1:0] hole_before;
      logic [AMT_FIELD_W-1:0] residue;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_wr;
      logic start;
      logic step;
      logic finish;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic span_zero;
      logic scan_last;
      logic out_free;
   } ctl_sts_type;

endpackage

`default_nettype wire

[rtl/fit_policy_hole_allocator_top.sv]
// ----------------------------------------------------------------------------
// fit_policy_hole_allocator_top
// first, best or worst fit search over a table of free hole sizes
// ----------------------------------------------------------------------------
//  channel  | ports                          | moves
//  ---------+--------------------------------+---------------------------------
//  request  | req_valid, req_ready, req      | load of a hole or an allocation
//  response | rsp_valid, rsp_ready, rsp      | one result per allocation
//  csr      | csr_we, csr_index, csr_wdata   | policy and holes in use
//
//  a load is written while idle; an allocation scans span entries, span being
//  the clipped holes in use, then drains and finishes (a zero span goes
//  straight to done); the scan reads one entry per cycle through the single read port of each table.
//  reset clears the table flags, so no clearing pass is needed.
//  a finished result waits in the output register while the next request is
//  taken; a following allocation holds in its last step until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fit_policy_hole_allocator_top import fph_pkg::*; #(
   parameter int NUM_HOLES = DEF_NUM_HOLES,
   parameter int SIZE_BITS = DEF_SIZE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   // sequencer
   fph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req.cmd),
      .req_ready (req_ready),
      .ctl_sts   (ctl_sts),
      .ctl_cmd   (ctl_cmd)
   );

   // tables and search
   fph_dpath #(
      .NUM_HOLES (NUM_HOLES),
      .SIZE_BITS (SIZE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctl_cmd   (ctl_cmd),
      .ctl_sts   (ctl_sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // checks
   logic alloc_fire;
   assign alloc_fire = req_valid && req_ready && (req.cmd == CMD_ALLOC);

   `ASSERT_IMPL(a_nofit_zero, rsp_valid && !rsp.granted, (rsp.chosen_hole == '0) && (rsp.hole_before == '0) && (rsp.residue == '0), "no-fit result with nonzero fields")
   `ASSERT_PROP(a_alloc_busy, alloc_fire |=> !req_ready, "request taken during an allocation")
   `ASSERT_PROP(a_rsp_after_work, $rose(rsp_valid) |-> $past(!req_ready), "result without an allocation in progress")

endmodule

`default_nettype wire

[rtl/fph_ctrl.sv]
// ----------------------------------------------------------------------------
// fph_ctrl
// sequencer: takes requests, steps the table scan, hands off the result
// ----------------------------------------------------------------------------
`default_nettype none

module fph_ctrl import fph_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_cmd,
   output logic             req_ready,
   input  wire ctl_sts_type ctl_sts,
   output ctl_cmd_type      ctl_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_ALLOC) begin
                  ctl_cmd.start = 1'b1;
                  state_in      = ctl_sts.span_zero ? ST_DONE : ST_SCAN;
               end else begin
                  ctl_cmd.load_wr = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            ctl_cmd.step = 1'b1;
            if (ctl_sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctl_sts.out_free) begin
               ctl_cmd.finish = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/fph_dpath.sv]
// ----------------------------------------------------------------------------
// fph_dpath
// hole tables, scan compare, best-hole tracking and result register
// ----------------------------------------------------------------------------
`default_nettype none

module fph_dpath import fph_pkg::*; #(
   parameter int NUM_HOLES = DEF_NUM_HOLES,
   parameter int SIZE_BITS = DEF_SIZE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire ctl_cmd_type           ctl_cmd,
   output ctl_sts_type                ctl_sts,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp
);

   localparam int IDX_W  = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;
   localparam int SPAN_W = $clog2(NUM_HOLES + 1);
   localparam int CMP_W  = (SPAN_W > HOLES_FIELD_W) ? SPAN_W : HOLES_FIELD_W;
   localparam int AMT_W  = (SIZE_BITS > AMT_FIELD_W) ? SIZE_BITS : AMT_FIELD_W;
   localparam logic [CMP_W-1:0] NUM_HOLES_C = CMP_W'(NUM_HOLES);

   // configuration registers
   logic [POLICY_W-1:0]      policy_ff;
   logic [HOLES_FIELD_W-1:0] holes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_RESET;
         holes_ff  <= HOLES_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_POLICY) begin
            policy_ff <= csr_wdata[POLICY_W-1:0];
         end else if (csr_index == CSR_HOLES_IN_USE) begin
            holes_ff <= csr_wdata[HOLES_FIELD_W-1:0];
         end
      end
   end

   // search span, clipped to the table
   logic [CMP_W-1:0] holes_ext;
   logic [CMP_W-1:0] span;
   logic [IDX_W-1:0] cnt_ff;
   logic [CMP_W-1:0] cnt_ext;

   assign holes_ext = CMP_W'(holes_ff);
   assign span      = (holes_ext > NUM_HOLES_C) ? NUM_HOLES_C : holes_ext;
   assign cnt_ext   = CMP_W'(cnt_ff);

   // load address and amount
   logic [CMP_W-1:0]     load_idx_ext;
   logic                 load_ok;
   logic [IDX_W-1:0]     load_addr;
   logic [AMT_W-1:0]     amt_ext;
   logic [SIZE_BITS-1:0] amt_sz;

   assign load_idx_ext = CMP_W'(req.hole_index);
   assign load_ok      = load_idx_ext < NUM_HOLES_C;
   assign load_addr    = load_idx_ext[IDX_W-1:0];
   assign amt_ext      = AMT_W'(req.amount);
   assign amt_sz       = amt_ext[SIZE_BITS-1:0];

   // request context and best hole so far
   logic [SIZE_BITS-1:0] amt_ff;
   logic                 last_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [SIZE_BITS-1:0] best_size_ff;
   logic [SIZE_BITS-1:0] residue_sz;
   logic                 wb_en;

   assign residue_sz = best_size_ff - amt_ff;
   assign wb_en      = ctl_cmd.finish && found_ff && !last_ff;

   // original sizes, one read port
   logic [SIZE_BITS-1:0] orig_mem [NUM_HOLES];
   logic [SIZE_BITS-1:0] orig_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl_cmd.load_wr && load_ok) begin
         orig_mem[load_addr] <= amt_sz;
      end
      if (ctl_cmd.step) begin
         orig_rd_ff <= orig_mem[cnt_ff];
      end
   end

   // working sizes of entries changed since the last restore
   logic [SIZE_BITS-1:0] work_mem [NUM_HOLES];
   logic [SIZE_BITS-1:0] work_rd_ff;

   always_ff @(posedge clock) begin
      if (wb_en) begin
         work_mem[best_idx_ff] <= residue_sz;
      end
      if (ctl_cmd.step) begin
         work_rd_ff <= work_mem[cnt_ff];
      end
   end

   // per-entry flags: original loaded, working copy differs from original
   logic [NUM_HOLES-1:0] orig_vld_ff;
   logic [NUM_HOLES-1:0] dirty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         orig_vld_ff <= '0;
         dirty_ff    <= '0;
      end else if (ctl_cmd.load_wr && load_ok) begin
         orig_vld_ff[load_addr] <= 1'b1;
         dirty_ff[load_addr]    <= 1'b0;
      end else if (ctl_cmd.finish && last_ff) begin
         dirty_ff <= '0;
      end else if (wb_en) begin
         dirty_ff[best_idx_ff] <= 1'b1;
      end
   end

   // read stage: flags and index alongside the memory data
   logic             orig_vld_rd_ff;
   logic             dirty_rd_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             cmp_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl_cmd.step) begin
         orig_vld_rd_ff <= orig_vld_ff[cnt_ff];
         dirty_rd_ff    <= dirty_ff[cnt_ff];
         rd_idx_ff      <= cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= ctl_cmd.step;
      end
   end

   // compare stage
   logic [SIZE_BITS-1:0] cur_size;
   logic                 fits;
   logic                 take;

   assign cur_size = dirty_rd_ff ? work_rd_ff : (orig_vld_rd_ff ? orig_rd_ff : '0);
   assign fits     = cur_size >= amt_ff;
   assign take     = fits && (!found_ff
                     || ((policy_ff == POLICY_BEST) && (cur_size < best_size_ff))
                     || ((policy_ff == POLICY_WORST) && (cur_size > best_size_ff)));

   // scan counter and request context
   always_ff @(posedge clock) begin
      if (ctl_cmd.start) begin
         cnt_ff  <= '0;
         amt_ff  <= amt_sz;
         last_ff <= req.last_request;
      end else if (ctl_cmd.step) begin
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
   end

   // best hole tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl_cmd.start) begin
         found_ff <= 1'b0;
      end else if (cmp_vld_ff && take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_vld_ff && take) begin
         best_idx_ff  <= rd_idx_ff;
         best_size_ff <= cur_size;
      end
   end

   // result build, zero fields when no hole fits
   logic [CMP_W-1:0] best_idx_ext;
   logic [AMT_W-1:0] before_ext;
   logic [AMT_W-1:0] residue_ext;
   rsp_type          rsp_in;

   assign best_idx_ext = CMP_W'(best_idx_ff);
   assign before_ext   = AMT_W'(best_size_ff);
   assign residue_ext  = AMT_W'(residue_sz);

   always_comb begin
      rsp_in = '0;
      if (found_ff) begin
         rsp_in.granted     = 1'b1;
         rsp_in.chosen_hole = best_idx_ext[IDX_FIELD_W-1:0];
         rsp_in.hole_before = before_ext[AMT_FIELD_W-1:0];
         rsp_in.residue     = residue_ext[AMT_FIELD_W-1:0];
      end
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl_cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // status to the controller
   assign ctl_sts.span_zero = (span == '0);
   assign ctl_sts.scan_last = ((cnt_ext + CMP_W'(1)) == span);
   assign ctl_sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire
